### rtl/lru_id_to_slot_mapper_macros.svh
// Assertion macros for the id-to-slot mapper.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef LRU_ID_TO_SLOT_MAPPER_MACROS_SVH
`define LRU_ID_TO_SLOT_MAPPER_MACROS_SVH

// consequent holds in the cycle after the antecedent
`define LIDSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LIDSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/lidsm_pkg.sv
// Shared types and constants for the id-to-slot mapper.
// No dependencies.
`default_nettype none
package lidsm_pkg;

  localparam int IDW = 32;   // id word width
  localparam int SNW = 5;    // reported slot number width

  typedef logic [IDW-1:0] id_t;

  typedef struct packed {
    logic upd;               // a valid id is being mapped this cycle
    logic miss;              // no cell holds the id
  } ctl_t;

endpackage
`default_nettype wire

### rtl/lidsm_cell.sv
// One recency cell: holds a stored id and its slot, compares against the key
// and takes its upper neighbour's entry when the row moves. Uses lidsm_pkg.
`default_nettype none
module lidsm_cell
  import lidsm_pkg::*;
#(
  parameter int SW       = 4,
  parameter int CELL_POS = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctl_t          ctl,
  input  wire id_t           key,
  input  wire id_t           nb_id,
  input  wire logic [SW-1:0] nb_slot,
  input  wire logic          hit_in,
  input  wire logic [SW-1:0] carry_in,
  output logic               hit_out,
  output logic [SW-1:0]      carry_out,
  output id_t                id_q,
  output logic [SW-1:0]      slot_q
);

  id_t           id_r,   id_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          match;
  logic          shift;

  assign match     = (id_r == key);
  assign hit_out   = hit_in | match;
  assign carry_out = match ? slot_r : carry_in;
  assign shift     = ctl.upd & (ctl.miss | hit_out);

  always_comb begin
    id_nxt   = id_r;
    slot_nxt = slot_r;
    if (shift) begin
      id_nxt   = nb_id;
      slot_nxt = nb_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r   <= '1;
      slot_r <= SW'(CELL_POS);
    end else begin
      id_r   <= id_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign id_q   = id_r;
  assign slot_q = slot_r;

endmodule
`default_nettype wire

### rtl/lru_id_to_slot_mapper.sv
// Top level of the LRU id-to-slot mapper: a row of recency cells.
// Uses lidsm_pkg, lidsm_cell and lru_id_to_slot_mapper_macros.svh.
//
// Usage:
//   An id word is taken when start is high and busy is low. busy stays low,
//   so a new id may be offered on every clock.
//   In the cycle after an id is taken, out_valid pulses for one cycle
//   with out_accepted and out_slot_number (slot counted from 1, 0 when the
//   id is negative and rejected). The receiver cannot stall the result.
//   Throughput is one id per cycle; the compare and the recency move of all
//   SLOTS cells are combinational and settle between the input edge and the
//   result register.
//   Cells are kept in recency order, oldest at position 0. A hit at
//   position p moves every cell above p down by one and puts the hit entry
//   on top; a miss does the same from position 0, overwriting the oldest.
//   Reset (rst_n low, synchronous) empties every slot and puts slot k at
//   position k, slot 0 being the oldest; no result is shown during reset.
`default_nettype none
`include "lru_id_to_slot_mapper_macros.svh"
module lru_id_to_slot_mapper
  import lidsm_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [IDW-1:0] in_id_number,
  output logic                       out_valid,
  output logic                       out_accepted,
  output logic [SNW-1:0]             out_slot_number
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  id_t           key;
  ctl_t          ctl;
  logic          take;
  logic          hit_c   [SLOTS+1];
  logic [SW-1:0] carry_c [SLOTS+1];
  id_t           cell_id   [SLOTS];
  logic [SW-1:0] cell_slot [SLOTS];
  id_t           nb_id     [SLOTS];
  logic [SW-1:0] nb_slot   [SLOTS];
  logic [SW:0]   slot_plus;

  logic           out_valid_r,    out_valid_nxt;
  logic           out_accepted_r, out_accepted_nxt;
  logic [SNW-1:0] out_slot_r,     out_slot_nxt;

  assign busy     = 1'b0;
  assign take     = start & ~busy;
  assign key      = id_t'(in_id_number);
  assign ctl.upd  = take & ~in_id_number[IDW-1];
  assign ctl.miss = ~hit_c[SLOTS];

  assign hit_c[0]   = 1'b0;
  assign carry_c[0] = cell_slot[0];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i == SLOTS-1) begin : g_top
      assign nb_id[i]   = key;
      assign nb_slot[i] = carry_c[SLOTS];
    end else begin : g_mid
      assign nb_id[i]   = cell_id[i+1];
      assign nb_slot[i] = cell_slot[i+1];
    end

    lidsm_cell #(
      .SW       (SW),
      .CELL_POS (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key       (key),
      .nb_id     (nb_id[i]),
      .nb_slot   (nb_slot[i]),
      .hit_in    (hit_c[i]),
      .carry_in  (carry_c[i]),
      .hit_out   (hit_c[i+1]),
      .carry_out (carry_c[i+1]),
      .id_q      (cell_id[i]),
      .slot_q    (cell_slot[i])
    );
  end

  assign slot_plus = {1'b0, carry_c[SLOTS]} + (SW+1)'(1);

  always_comb begin
    out_valid_nxt    = take;
    out_accepted_nxt = ctl.upd;
    out_slot_nxt     = ctl.upd ? SNW'(slot_plus) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_accepted_r <= out_accepted_nxt;
    out_slot_r     <= out_slot_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_accepted    = out_accepted_r;
  assign out_slot_number = out_slot_r;

  `LIDSM_ASSERT_NEXT(a_result_follows, start && !busy, out_valid, "result word missing")
  `LIDSM_ASSERT_NEXT(a_no_spurious, !start, !out_valid, "result word without input")
  `LIDSM_ASSERT_NEXT(a_neg_rejected, start && !busy && in_id_number[IDW-1], !out_accepted, "negative id accepted")
  `LIDSM_ASSERT_NOW(a_reject_zero, out_valid && !out_accepted, out_slot_number == '0, "rejected word has a slot")

endmodule
`default_nettype wire

### tb/sv/lru_id_to_slot_mapper_tb.sv
// Testbench for lru_id_to_slot_mapper: a directed table, then random id words
// checked against an LRU slot predictor held here. Needs lidsm_pkg and the RTL.
`default_nettype none
module lru_id_to_slot_mapper_tb;
  import lidsm_pkg::*;

  localparam int SLOTS = 16;
  localparam int DIR_ROWS = 23;
  localparam int RAND_ITEMS = 1850;
  localparam int CALM_TAIL = 200;
  localparam int HOT_IDS = 20;

  typedef struct packed {
    logic           acc;
    logic [SNW-1:0] slot;
  } slot_map_t;

  typedef struct packed {
    logic [IDW-1:0] id;
    logic           typed;
    logic           acc;
    logic [SNW-1:0] slot;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic signed [IDW-1:0] in_id_number;
  logic                  out_valid;
  logic                  out_accepted;
  logic [SNW-1:0]        out_slot_number;

  id_t       held_id [SLOTS];
  int        recency [SLOTS];   // slot indices, oldest first
  slot_map_t pending_maps[$];
  int        errors;

  dir_row_t dir_rows [DIR_ROWS] = '{
    {32'd100,       1'b1, 1'b1, 5'd1},
    {32'hFFFF_FFFF, 1'b1, 1'b0, 5'd0},
    {32'h8000_0000, 1'b1, 1'b0, 5'd0},
    {32'h7FFF_FFFF, 1'b1, 1'b1, 5'd2},
    {32'd0,         1'b1, 1'b1, 5'd3},
    {32'd0,         1'b1, 1'b1, 5'd3},   // hit on newest
    {32'd100,       1'b1, 1'b1, 5'd1},
    {32'd1,  1'b0, 1'b0, 5'd0}, {32'd2,  1'b0, 1'b0, 5'd0},
    {32'd3,  1'b0, 1'b0, 5'd0}, {32'd4,  1'b0, 1'b0, 5'd0},
    {32'd5,  1'b0, 1'b0, 5'd0}, {32'd6,  1'b0, 1'b0, 5'd0},
    {32'd7,  1'b0, 1'b0, 5'd0}, {32'd8,  1'b0, 1'b0, 5'd0},
    {32'd9,  1'b0, 1'b0, 5'd0}, {32'd10, 1'b0, 1'b0, 5'd0},
    {32'd11, 1'b0, 1'b0, 5'd0}, {32'd12, 1'b0, 1'b0, 5'd0},
    {32'd13, 1'b0, 1'b0, 5'd0},
    {32'd14,        1'b0, 1'b0, 5'd0},   // evicts an id still in use
    {32'h7FFF_FFFF, 1'b0, 1'b0, 5'd0},
    {32'h8000_0001, 1'b1, 1'b0, 5'd0}
  };

  lru_id_to_slot_mapper #(.SLOTS(SLOTS)) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_id_number    (in_id_number),
    .out_valid       (out_valid),
    .out_accepted    (out_accepted),
    .out_slot_number (out_slot_number)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // LRU predictor: hit or oldest slot moves to the newest position
  function automatic slot_map_t map_id(input id_t id);
    slot_map_t r;
    int        pos;
    int        s;
    r = '0;
    if (id[IDW-1]) return r;
    pos = 0;
    for (int p = 0; p < SLOTS; p++)
      if (held_id[recency[p]] == id) pos = p;
    s = recency[pos];
    for (int p = pos; p < SLOTS - 1; p++) recency[p] = recency[p+1];
    recency[SLOTS-1] = s;
    held_id[s] = id;
    r.acc = 1'b1;
    r.slot = SNW'(s + 1);
    return r;
  endfunction

  task automatic offer(input dir_row_t row);
    slot_map_t predicted;
    @(negedge clk);
    start <= 1'b1;
    in_id_number <= row.id;
    do @(posedge clk); while (busy);
    predicted = map_id(row.id);
    if (row.typed) pending_maps.push_back({row.acc, row.slot});
    else pending_maps.push_back(predicted);
  endtask

  task automatic idle_burst(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    in_id_number <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    slot_map_t want;
    if (rst_n && out_valid) begin
      if (pending_maps.size() == 0) begin
        $display("%0t: unexpected word acc=%0b slot=%0d", $time, out_accepted,
                 out_slot_number);
        errors++;
      end else begin
        want = pending_maps.pop_front();
        if (out_accepted !== want.acc) begin
          $display("%0t: accepted exp %0b got %0b", $time, want.acc, out_accepted);
          errors++;
        end
        if (out_slot_number !== want.slot) begin
          $display("%0t: slot exp %0d got %0d", $time, want.slot, out_slot_number);
          errors++;
        end
      end
    end
  end

  initial begin
    id_t         id;
    id_t         last_id;
    id_t         hot [HOT_IDS];
    int          kind;
    int unsigned gap_odds;
    dir_row_t    row;
    errors = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_id_number = '0;
    for (int k = 0; k < SLOTS; k++) begin
      held_id[k] = '1;
      recency[k] = k;
    end
    for (int k = 0; k < HOT_IDS; k++)
      hot[k] = (k < 8) ? id_t'(k) : ($urandom & 32'h7FFF_FFFF);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) offer(dir_rows[i]);

    last_id = '0;
    gap_odds = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) gap_odds = $urandom_range(0, 2) * 4;
      if (i < RAND_ITEMS - CALM_TAIL && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        idle_burst($urandom_range(1, 17));
      if ($urandom_range(0, 29) == 0)
        hot[$urandom_range(0, HOT_IDS-1)] = $urandom & 32'h7FFF_FFFF;
      kind = $urandom_range(0, 99);
      if (kind < 60) id = hot[$urandom_range(0, HOT_IDS-1)];
      else if (kind < 70) id = last_id;
      else if (kind < 82) id = $urandom | 32'h8000_0000;
      else id = $urandom;
      last_id = id;
      row = '0;
      row.id = id;
      offer(row);
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
